FILE: hdl/purms_pkg.sv
// ----------------------------------------------------------------------------
// purms_pkg: shared types and constants of the per-user rating statistics
// Field widths, datapath widths, sequencer states and the one-rating deviation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package purms_pkg;

  // field widths
  localparam int ID_W   = 19;
  localparam int CNT_W  = 16;
  localparam int FRAC_W = 16;
  localparam int RAT_W  = 3;

  // accumulator and datapath widths
  localparam int SUM_W  = CNT_W + 3;            // sum of ratings
  localparam int SQS_W  = CNT_W + 6;            // sum of squared ratings
  localparam int STAT_W = FRAC_W + 3;           // Q3.FRAC result
  localparam int MUL_W  = SQS_W;                // shared multiplier operand
  localparam int PROD_W = 2 * CNT_W + 6;        // n*sumsq and sum^2
  localparam int RAD_W  = PROD_W + 2 * FRAC_W;  // scaled radicand
  localparam int ROOT_W = RAD_W / 2;            // root of the radicand
  localparam int REM_W  = ROOT_W + 3;           // shared subtractor width
  localparam int QUO_W  = STAT_W;               // quotient bits per division
  localparam int STEP_W = $clog2(ROOT_W);       // iteration counter

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MULQ,
    S_MULS,
    S_DIFF,
    S_SQRT,
    S_LDS,
    S_DIVS,
    S_LDM,
    S_DIVM,
    S_OUT
  } seq_state_e;

  // integer square root, used at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] r;
    logic [63:0] bitv;
    rem  = x;
    r    = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + bitv) begin
        rem = rem - (r + bitv);
        r   = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // deviation reported for a user with a single rating: 4/sqrt(12)
  localparam logic [63:0] STDEV_ONE_WIDE = isqrt64((64'd1 << (2 * FRAC_W + 2)) / 64'd3);
  localparam logic [STAT_W-1:0] STDEV_ONE = STDEV_ONE_WIDE[STAT_W-1:0];

endpackage

FILE: hdl/purms_if.sv
// ----------------------------------------------------------------------------
// purms_if: valid/ready channels of the per-user rating statistics
// Input channel carries rating records and flushes; output carries user stats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface purms_in_if import purms_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [ID_W-1:0]  user_id;
  logic [RAT_W-1:0] rating;

  modport source (output valid, output cmd, output user_id, output rating, input ready);
  modport sink   (input valid, input cmd, input user_id, input rating, output ready);
endinterface

interface purms_out_if import purms_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   closed_user_id;
  logic [STAT_W-1:0] mean_q16;
  logic [STAT_W-1:0] stdev_q16;
  logic [CNT_W-1:0]  rating_count;
  logic [ID_W-1:0]   skipped_ids;
  logic              count_overflow;

  modport source (output valid, output closed_user_id, output mean_q16, output stdev_q16,
                  output rating_count, output skipped_ids, output count_overflow,
                  input ready);
  modport sink   (input valid, input closed_user_id, input mean_q16, input stdev_q16,
                  input rating_count, input skipped_ids, input count_overflow,
                  output ready);
endinterface

FILE: hdl/per_user_rating_mean_stdev_top.sv
// ----------------------------------------------------------------------------
// per_user_rating_mean_stdev_top: per-user mean and population deviation
// A record that does not close a user leaves the input ready; the next may follow.
// A record or flush that closes a user starts the sequencer: two products on
// the shared multiplier, a ROOT_W-step square root and two STAT_W-step
// divisions on one shared subtractor; the result is then registered once the
// output register is free, and the input is ready again.
// Reset (async, active low) clears the open user, counters and output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_user_rating_mean_stdev_top import purms_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  purms_in_if.sink       in_i,
  purms_out_if.source    out_o
);

  // open-user accumulators
  logic [ID_W-1:0]   cur_q, cur_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SQS_W-1:0]  sqs_q, sqs_d;
  logic              ovf_q, ovf_d;
  logic [ID_W-1:0]   prev_q, prev_d;

  // snapshot of the user being closed
  logic [ID_W-1:0]   snap_id_q;
  logic [CNT_W-1:0]  snap_n_q;
  logic [SUM_W-1:0]  snap_s_q;
  logic [SQS_W-1:0]  snap_sq_q;
  logic [ID_W-1:0]   snap_skip_q;
  logic              snap_ovf_q;

  // sequencer and shared datapath
  seq_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q;
  logic [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0] ssq_q;
  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [QUO_W-1:0]  num_q;
  logic [QUO_W-1:0]  quo_q;
  logic [STAT_W-1:0] stdev_q;

  // output register
  logic              out_valid_q;
  logic [ID_W-1:0]   out_id_q;
  logic [STAT_W-1:0] out_mean_q;
  logic [STAT_W-1:0] out_stdev_q;
  logic [CNT_W-1:0]  out_cnt_q;
  logic [ID_W-1:0]   out_skip_q;
  logic              out_ovf_q;

  logic              in_xfer;
  logic              emit;
  logic              out_free;
  logic [5:0]        rat_sq;
  logic [ID_W-1:0]   skip;

  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;
  logic [REM_W-1:0]   alu_a, alu_b;
  logic [REM_W:0]     alu_diff;
  logic               alu_ge;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign rat_sq   = {3'b000, in_i.rating} * {3'b000, in_i.rating};
  assign skip     = (cur_q > prev_q) ? (cur_q - prev_q - ID_W'(1)) : '0;

  // a record with a higher id or a flush closes the open user
  assign emit = (cur_q != '0) && (in_i.cmd || (in_i.user_id > cur_q));

  // accumulator update
  always_comb begin
    cur_d   = cur_q;
    total_d = total_q;
    sum_d   = sum_q;
    sqs_d   = sqs_q;
    ovf_d   = ovf_q;
    prev_d  = prev_q;
    if (in_xfer) begin
      if (emit) begin
        prev_d = cur_q;
      end
      if (in_i.cmd) begin
        cur_d   = '0;
        total_d = '0;
        sum_d   = '0;
        sqs_d   = '0;
        ovf_d   = 1'b0;
      end else if (in_i.user_id != '0 && (cur_q == '0 || in_i.user_id > cur_q)) begin
        // open a new user with this rating
        cur_d   = in_i.user_id;
        total_d = CNT_W'(1);
        sum_d   = SUM_W'(in_i.rating);
        sqs_d   = SQS_W'(rat_sq);
        ovf_d   = 1'b0;
      end else if (cur_q != '0) begin
        // join the open user
        if (total_q == CNT_MAX) begin
          ovf_d = 1'b1;
        end else begin
          total_d = total_q + CNT_W'(1);
          sum_d   = sum_q + SUM_W'(in_i.rating);
          sqs_d   = sqs_q + SQS_W'(rat_sq);
        end
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_xfer && emit) state_d = S_MULQ;
      S_MULQ: state_d = S_MULS;
      S_MULS: state_d = S_DIFF;
      S_DIFF: state_d = S_SQRT;
      S_SQRT: if (step_q == '0) state_d = S_LDS;
      S_LDS:  state_d = S_DIVS;
      S_DIVS: if (step_q == '0) state_d = S_LDM;
      S_LDM:  state_d = S_DIVM;
      S_DIVM: if (step_q == '0) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // shared multiplier and subtractor operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    alu_a = '0;
    alu_b = '0;
    case (state_q)
      S_MULQ: begin
        mul_a = MUL_W'(snap_n_q);
        mul_b = MUL_W'(snap_sq_q);
      end
      S_MULS: begin
        mul_a = MUL_W'(snap_s_q);
        mul_b = MUL_W'(snap_s_q);
      end
      S_SQRT: begin
        alu_a = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
        alu_b = {1'b0, root_q, 2'b01};
      end
      S_DIVS, S_DIVM: begin
        alu_a = REM_W'({rem_q[CNT_W-1:0], num_q[QUO_W-1]});
        alu_b = REM_W'(snap_n_q);
      end
      default: ;
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_ge   = !alu_diff[REM_W];

  assign in_i.ready = (state_q == S_IDLE);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      total_q     <= '0;
      sum_q       <= '0;
      sqs_q       <= '0;
      ovf_q       <= 1'b0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      total_q <= total_d;
      sum_q   <= sum_d;
      sqs_q   <= sqs_d;
      ovf_q   <= ovf_d;
      prev_q  <= prev_d;
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // snapshot and iterative datapath
  always_ff @(posedge clk_i) begin
    if (in_xfer && emit) begin
      snap_id_q   <= cur_q;
      snap_n_q    <= total_q;
      snap_s_q    <= sum_q;
      snap_sq_q   <= sqs_q;
      snap_skip_q <= skip;
      snap_ovf_q  <= ovf_q;
    end
    case (state_q)
      S_MULQ: prod_q <= mul_p[PROD_W-1:0];
      S_MULS: ssq_q  <= mul_p[PROD_W-1:0];
      S_DIFF: begin
        rad_q  <= {prod_q - ssq_q, {(2 * FRAC_W){1'b0}}};
        rem_q  <= '0;
        root_q <= '0;
        step_q <= STEP_W'(ROOT_W - 1);
      end
      S_SQRT: begin
        // one root bit per step
        rad_q  <= rad_q << 2;
        rem_q  <= alu_ge ? alu_diff[REM_W-1:0] : alu_a;
        root_q <= {root_q[ROOT_W-2:0], alu_ge};
        step_q <= step_q - STEP_W'(1);
      end
      S_LDS: begin
        rem_q  <= REM_W'(root_q[ROOT_W-1:QUO_W]);
        num_q  <= root_q[QUO_W-1:0];
        step_q <= STEP_W'(QUO_W - 1);
      end
      S_DIVS, S_DIVM: begin
        // restoring division, one quotient bit per step
        rem_q  <= alu_ge ? alu_diff[REM_W-1:0] : alu_a;
        num_q  <= num_q << 1;
        quo_q  <= {quo_q[QUO_W-2:0], alu_ge};
        step_q <= step_q - STEP_W'(1);
      end
      S_LDM: begin
        stdev_q <= quo_q;
        rem_q   <= REM_W'(snap_s_q[SUM_W-1:QUO_W-FRAC_W]);
        num_q   <= {snap_s_q[QUO_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
        step_q  <= STEP_W'(QUO_W - 1);
      end
      default: ;
    endcase
    if (state_q == S_OUT && out_free) begin
      out_id_q    <= snap_id_q;
      out_mean_q  <= quo_q;
      out_stdev_q <= (snap_n_q == CNT_W'(1)) ? STDEV_ONE : stdev_q;
      out_cnt_q   <= snap_n_q;
      out_skip_q  <= snap_skip_q;
      out_ovf_q   <= snap_ovf_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.closed_user_id = out_id_q;
  assign out_o.mean_q16       = out_mean_q;
  assign out_o.stdev_q16      = out_stdev_q;
  assign out_o.rating_count   = out_cnt_q;
  assign out_o.skipped_ids    = out_skip_q;
  assign out_o.count_overflow = out_ovf_q;

`ifndef SYNTHESIS
  // a result appears only at the end of a closing sequence
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("result raised outside the closing sequence");

  // with no user open the accumulators stay clear
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q == '0) |-> (total_q == '0 && sum_q == '0 && sqs_q == '0 && !ovf_q))
    else $error("accumulators hold data with no user open");

  // the division remainder stays below the rating count
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVS || state_q == S_DIVM) |->
      (rem_q[CNT_W-1:0] < snap_n_q && rem_q[REM_W-1:CNT_W] == '0))
    else $error("division remainder out of range");
`endif

endmodule
